@@ design/assert_macros.svh @@
// Assertion macros shared by the splitter modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression holds at every clock edge outside reset.
`define SLOS_ASSERT_HOLDS(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("invariant violated");

// The consequent holds in the same cycle as the antecedent.
`define SLOS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication violated");

// The consequent holds in the cycle after the antecedent.
`define SLOS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle implication violated");

`endif

@@ design/slos_pkg.sv @@
// Shared constants and types of the command line splitter.
package slos_pkg;

	localparam int unsigned MaxLineBytes = 4096;
	localparam int unsigned CNT_W = 13;
	localparam int unsigned IDX_W = 12;
	localparam int unsigned PieceCapInt = (MaxLineBytes < 4096) ? MaxLineBytes : 4096;
	localparam logic [CNT_W-1:0] PIECE_CAP = CNT_W'(PieceCapInt);

	// Characters with a meaning to the scanner.
	localparam logic [7:0] CH_PIPE   = 8'h7C;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_AMP    = 8'h26;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_DQUOTE = 8'h22;

	// Result queue geometry.
	localparam int unsigned QueueDepth = 4;
	localparam int unsigned QPTR_W = $clog2(QueueDepth);
	localparam int unsigned QCNT_W = $clog2(QueueDepth + 1);

	typedef struct packed {
		logic [7:0]       byte_out;
		logic             piece_start;
		logic             piece_is_operator;
		logic [IDX_W-1:0] piece_index;
		logic             last;
		logic             quote_error;
		logic [CNT_W-1:0] piece_count;
	} res_t;

	// Results produced by one accepted byte, in output order.
	typedef struct packed {
		logic [1:0] count;
		res_t       first;
		res_t       second;
	} push_t;

endpackage

@@ design/slos_in_if.sv @@
// Input channel: one byte of the command line per transfer.
interface slos_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_in;
	logic       line_end;

	modport source (output valid, output byte_in, output line_end, input ready);
	modport sink (input valid, input byte_in, input line_end, output ready);
endinterface

@@ design/slos_out_if.sv @@
// Output channel: one classified byte per transfer.
interface slos_out_if;
	import slos_pkg::*;

	logic             valid;
	logic             ready;
	logic [7:0]       byte_out;
	logic             piece_start;
	logic             piece_is_operator;
	logic [IDX_W-1:0] piece_index;
	logic             last;
	logic             quote_error;
	logic [CNT_W-1:0] piece_count;

	modport source (output valid, output byte_out, output piece_start,
		output piece_is_operator, output piece_index, output last,
		output quote_error, output piece_count, input ready);
	modport sink (input valid, input byte_out, input piece_start,
		input piece_is_operator, input piece_index, input last,
		input quote_error, input piece_count, output ready);
endinterface

@@ design/shell_line_operator_splitter_top.sv @@
// A byte's result enters the result queue when the next byte of the line is accepted;
// a line's final byte and the byte held before it both enter as the final byte is accepted.
// Throughput: one byte per cycle while the queue has room for two more results; a final byte
// after a held byte yields two results, drained from the four-entry queue one per transfer.
// Reset (arst_n low, asynchronous): scanner idle, no held byte, piece counter zero,
// result queue empty.
module shell_line_operator_splitter_top (
	input  logic      clk,
	input  logic      arst_n,
	slos_in_if.sink   in_ch,
	slos_out_if.source out_ch
);
	import slos_pkg::*;

	// The scanner holds one byte back so that a following ampersand can be seen before
	// the held byte is classified: an ampersand in a command piece opens an operator
	// piece only when another ampersand comes right after it.
	logic  accept;
	push_t push;
	logic  space_ok;

	// The input side is ready whenever the queue can take two more results, which does
	// not depend on whether the output side is taking results in this cycle.
	assign in_ch.ready = space_ok;
	assign accept      = in_ch.valid && in_ch.ready;

	// Classification of the held byte and, at line end, of the final byte, all in the
	// cycle of the input transfer; results go straight into the queue registers.
	slos_scanner u_scanner (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.byte_in  (in_ch.byte_in),
		.line_end (in_ch.line_end),
		.push     (push)
	);

	// Results leave in order, one per output transfer.
	slos_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.space_ok (space_ok),
		.out_ch   (out_ch)
	);

endmodule

@@ design/slos_scanner.sv @@
// Scan state, held byte and per-byte classification of the splitter.
`include "assert_macros.svh"

module slos_scanner (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  logic [7:0]         byte_in,
	input  logic               line_end,
	output slos_pkg::push_t    push
);
	import slos_pkg::*;

	localparam logic [2:0] MODE_IDLE    = 3'd0;
	localparam logic [2:0] MODE_CMD     = 3'd1;
	localparam logic [2:0] MODE_ESC     = 3'd2;
	localparam logic [2:0] MODE_SQ      = 3'd3;
	localparam logic [2:0] MODE_DQ      = 3'd4;
	localparam logic [2:0] MODE_OP_PIPE = 3'd5;
	localparam logic [2:0] MODE_OP_SEMI = 3'd6;
	localparam logic [2:0] MODE_OP_AMP  = 3'd7;

	typedef struct packed {
		logic [2:0]       mode;
		logic [CNT_W-1:0] count;
		logic             start;
		logic             op;
		logic [IDX_W-1:0] idx;
	} step_t;

	function automatic logic [2:0] op_mode(input logic [7:0] c);
		logic [2:0] m;
		if (c == CH_PIPE) begin
			m = MODE_OP_PIPE;
		end else if (c == CH_SEMI) begin
			m = MODE_OP_SEMI;
		end else begin
			m = MODE_OP_AMP;
		end
		return m;
	endfunction

	function automatic logic [2:0] cmd_next(input logic [7:0] c);
		logic [2:0] m;
		if (c == CH_BSLASH) begin
			m = MODE_ESC;
		end else if (c == CH_SQUOTE) begin
			m = MODE_SQ;
		end else if (c == CH_DQUOTE) begin
			m = MODE_DQ;
		end else begin
			m = MODE_CMD;
		end
		return m;
	endfunction

	// One byte through the scanner: new mode, piece counter and flags.
	function automatic step_t classify(input logic [2:0] m, input logic [CNT_W-1:0] cnt,
			input logic [7:0] h, input logic amp_next);
		step_t            s;
		logic             in_op;
		logic             is_opc;
		logic             fresh;
		logic [7:0]       opc;
		logic [CNT_W-1:0] dec;
		s.mode  = m;
		s.count = cnt;
		s.start = 1'b0;
		s.op    = 1'b0;
		in_op   = (m == MODE_OP_PIPE) || (m == MODE_OP_SEMI) || (m == MODE_OP_AMP);
		is_opc  = (h == CH_PIPE) || (h == CH_SEMI) || (h == CH_AMP);
		case (m)
			MODE_OP_PIPE: opc = CH_PIPE;
			MODE_OP_SEMI: opc = CH_SEMI;
			default:      opc = CH_AMP;
		endcase
		fresh = (m == MODE_IDLE) || (in_op && (h != opc));
		if (fresh) begin
			s.start = 1'b1;
			if (is_opc) begin
				s.op   = 1'b1;
				s.mode = op_mode(h);
			end else begin
				s.mode = cmd_next(h);
			end
		end else if (in_op) begin
			// Doubled operator character closes the operator piece.
			s.op   = 1'b1;
			s.mode = MODE_IDLE;
		end else begin
			case (m)
				MODE_CMD: begin
					if ((h == CH_PIPE) || (h == CH_SEMI) || ((h == CH_AMP) && amp_next)) begin
						s.start = 1'b1;
						s.op    = 1'b1;
						s.mode  = op_mode(h);
					end else begin
						s.mode = cmd_next(h);
					end
				end
				MODE_ESC: s.mode = MODE_CMD;
				MODE_SQ: begin
					if (h == CH_SQUOTE) begin
						s.mode = MODE_CMD;
					end
				end
				MODE_DQ: begin
					if (h == CH_DQUOTE) begin
						s.mode = MODE_CMD;
					end
				end
				default: s.mode = m;
			endcase
		end
		if (s.start && (cnt < PIECE_CAP)) begin
			s.count = cnt + 1'b1;
		end
		dec   = s.count - 1'b1;
		s.idx = (s.count == '0) ? '0 : dec[IDX_W-1:0];
		return s;
	endfunction

	logic [2:0]       mode_q;
	logic [CNT_W-1:0] count_q;
	logic [7:0]       held_byte_q;
	logic             held_valid_q;

	step_t            step_a;
	step_t            step_b;
	logic [2:0]       mode_mid;
	logic [CNT_W-1:0] count_mid;
	res_t             res_a;
	res_t             res_b;
	logic             qerr;

	always_comb begin
		step_a    = classify(mode_q, count_q, held_byte_q, byte_in == CH_AMP);
		mode_mid  = held_valid_q ? step_a.mode : mode_q;
		count_mid = held_valid_q ? step_a.count : count_q;
		step_b    = classify(mode_mid, count_mid, byte_in, 1'b0);
		qerr      = (step_b.mode == MODE_SQ) || (step_b.mode == MODE_DQ);

		res_a.byte_out          = held_byte_q;
		res_a.piece_start       = step_a.start;
		res_a.piece_is_operator = step_a.op;
		res_a.piece_index       = step_a.idx;
		res_a.last              = 1'b0;
		res_a.quote_error       = 1'b0;
		res_a.piece_count       = '0;

		res_b.byte_out          = byte_in;
		res_b.piece_start       = step_b.start;
		res_b.piece_is_operator = step_b.op;
		res_b.piece_index       = step_b.idx;
		res_b.last              = 1'b1;
		res_b.quote_error       = qerr;
		res_b.piece_count       = qerr ? '0 : step_b.count;

		push.count  = accept ? ({1'b0, held_valid_q} + {1'b0, line_end}) : 2'd0;
		push.first  = held_valid_q ? res_a : res_b;
		push.second = res_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= MODE_IDLE;
			count_q      <= '0;
			held_valid_q <= 1'b0;
		end else if (accept) begin
			if (line_end) begin
				mode_q       <= MODE_IDLE;
				count_q      <= '0;
				held_valid_q <= 1'b0;
			end else begin
				mode_q       <= mode_mid;
				count_q      <= count_mid;
				held_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !line_end) begin
			held_byte_q <= byte_in;
		end
	end

	`SLOS_ASSERT_NEXT(a_held_after_mid, clk, arst_n, accept && !line_end, held_valid_q)
	`SLOS_ASSERT_NEXT(a_clear_after_end, clk, arst_n, accept && line_end,
		!held_valid_q && (count_q == '0) && (mode_q == MODE_IDLE))
	`SLOS_ASSERT_IMP(a_idle_when_empty, clk, arst_n, !held_valid_q,
		(count_q == '0) && (mode_q == MODE_IDLE))

endmodule

@@ design/slos_queue.sv @@
// Result queue: takes up to two results per cycle, delivers one per transfer.
`include "assert_macros.svh"

module slos_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  slos_pkg::push_t   push,
	output logic              space_ok,
	slos_out_if.source        out_ch
);
	import slos_pkg::*;

	res_t              entry_q [QueueDepth];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              pop;
	res_t              head;

	assign head     = entry_q[rd_ptr_q];
	assign pop      = out_ch.valid && out_ch.ready;
	// Room for the worst case of two results from one byte.
	assign space_ok = count_q <= QCNT_W'(QueueDepth - 2);

	assign out_ch.valid             = count_q != '0;
	assign out_ch.byte_out          = head.byte_out;
	assign out_ch.piece_start       = head.piece_start;
	assign out_ch.piece_is_operator = head.piece_is_operator;
	assign out_ch.piece_index       = head.piece_index;
	assign out_ch.last              = head.last;
	assign out_ch.quote_error       = head.quote_error;
	assign out_ch.piece_count       = head.piece_count;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + QPTR_W'(push.count);
			rd_ptr_q <= rd_ptr_q + QPTR_W'(pop);
			count_q  <= count_q + QCNT_W'(push.count) - QCNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			entry_q[wr_ptr_q] <= push.first;
		end
		if (push.count == 2'd2) begin
			entry_q[wr_ptr_q + 1'b1] <= push.second;
		end
	end

	`SLOS_ASSERT_HOLDS(a_count_bound, clk, arst_n, count_q <= QCNT_W'(QueueDepth))
	`SLOS_ASSERT_IMP(a_push_has_room, clk, arst_n, push.count != 2'd0, space_ok)
	`SLOS_ASSERT_NEXT(a_pop_drains, clk, arst_n, pop && (push.count == 2'd0),
		count_q == $past(count_q) - 1'b1)

endmodule

@@ sim/tb_shell_line_operator_splitter_top.sv @@
// Self-checking testbench for the shell command line operator splitter.
`timescale 1ns / 1ps

module tb_shell_line_operator_splitter_top;
	import slos_pkg::*;

	// The scanner's modes, as this bench tracks them.
	typedef enum logic [2:0] {
		SCAN_IDLE,
		SCAN_CMD,
		SCAN_ESC,
		SCAN_SQ,
		SCAN_DQ,
		SCAN_OP_PIPE,
		SCAN_OP_SEMI,
		SCAN_OP_AMP
	} scan_state_t;

	// One byte of a command line, with its end-of-line mark.
	typedef struct packed {
		logic [7:0] ch;
		logic       fin;
	} line_item_t;

	localparam int unsigned StallLimit = 1000;
	localparam int unsigned RandomBytes = 1000;
	localparam int unsigned QuietFrom = 300;
	localparam int unsigned QuietTo = 600;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	// Local copies of every block input, so they hold known values from time zero.
	logic       in_valid = 1'b0;
	logic [7:0] in_byte = 8'h00;
	logic       in_fin = 1'b0;
	logic       out_ready = 1'b0;

	slos_in_if in_ch ();
	slos_out_if out_ch ();

	assign in_ch.valid = in_valid;
	assign in_ch.byte_in = in_byte;
	assign in_ch.line_end = in_fin;
	assign out_ch.ready = out_ready;

	shell_line_operator_splitter_top DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	always #2 clk = ~clk;

	// Bytes waiting to be offered, results the splitter still owes, and the line being built.
	line_item_t send_queue[$];
	res_t       predicted_bytes[$];
	logic [7:0] line_buf[$];

	string op_texts[6] = '{"|", "||", ";", ";;", "&", "&&"};

	int unsigned mismatch_count = 0;
	int unsigned cycle_count = 0;
	int unsigned stall_count = 0;

	// Shadow of the splitter's scanning state.
	scan_state_t      scan_state = SCAN_IDLE;
	logic [7:0]       held_ch = 8'h00;
	logic             held_valid = 1'b0;
	logic [CNT_W-1:0] piece_total = '0;

	function automatic bit is_op_char(logic [7:0] c);
		return c == CH_PIPE || c == CH_SEMI || c == CH_AMP;
	endfunction

	function automatic scan_state_t op_state_of(logic [7:0] c);
		if (c == CH_PIPE) return SCAN_OP_PIPE;
		if (c == CH_SEMI) return SCAN_OP_SEMI;
		return SCAN_OP_AMP;
	endfunction

	function automatic scan_state_t cmd_state_of(logic [7:0] c);
		if (c == CH_BSLASH) return SCAN_ESC;
		if (c == CH_SQUOTE) return SCAN_SQ;
		if (c == CH_DQUOTE) return SCAN_DQ;
		return SCAN_CMD;
	endfunction

	// Classifies one byte of the line and advances the shadow scanner. The flag says whether
	// the byte that follows it is an ampersand, which is what decides a double ampersand.
	function automatic res_t classify_byte(logic [7:0] h, logic amp_follows);
		res_t        r;
		scan_state_t m;
		logic        in_op;
		logic [7:0]  op_ch;
		logic        fresh;
		logic        starts;
		logic        is_op;

		m = scan_state;
		in_op = m inside {SCAN_OP_PIPE, SCAN_OP_SEMI, SCAN_OP_AMP};
		op_ch = (m == SCAN_OP_PIPE) ? CH_PIPE : (m == SCAN_OP_SEMI) ? CH_SEMI : CH_AMP;
		fresh = (m == SCAN_IDLE) || (in_op && h != op_ch);
		starts = 1'b0;
		is_op = 1'b0;
		if (fresh) begin
			starts = 1'b1;
			if (is_op_char(h)) begin
				is_op = 1'b1;
				scan_state = op_state_of(h);
			end else begin
				scan_state = cmd_state_of(h);
			end
		end else if (in_op) begin
			// The doubled operator character closes the operator piece.
			is_op = 1'b1;
			scan_state = SCAN_IDLE;
		end else if (m == SCAN_CMD) begin
			if (h == CH_PIPE || h == CH_SEMI || (h == CH_AMP && amp_follows)) begin
				starts = 1'b1;
				is_op = 1'b1;
				scan_state = op_state_of(h);
			end else begin
				scan_state = cmd_state_of(h);
			end
		end else if (m == SCAN_ESC) begin
			scan_state = SCAN_CMD;
		end else if (m == SCAN_SQ) begin
			if (h == CH_SQUOTE) scan_state = SCAN_CMD;
		end else begin
			if (h == CH_DQUOTE) scan_state = SCAN_CMD;
		end

		// The counter saturates; later pieces still start but share the last index.
		if (starts && piece_total < PIECE_CAP) piece_total = piece_total + 1'b1;

		r = '0;
		r.byte_out = h;
		r.piece_start = starts;
		r.piece_is_operator = is_op;
		if (piece_total == '0) r.piece_index = '0;
		else if (piece_total - 1'b1 > CNT_W'(4095)) r.piece_index = '1;
		else r.piece_index = IDX_W'(piece_total - 1'b1);
		return r;
	endfunction

	// Works out what one accepted byte causes: the held byte's result, and on the last byte
	// of a line also that byte's result with the line summary.
	task automatic predict_line_byte(logic [7:0] b, logic fin);
		res_t r;
		logic qerr;

		if (held_valid) predicted_bytes.push_back(classify_byte(held_ch, b == CH_AMP));
		if (fin) begin
			r = classify_byte(b, 1'b0);
			qerr = (scan_state == SCAN_SQ) || (scan_state == SCAN_DQ);
			r.last = 1'b1;
			r.quote_error = qerr;
			r.piece_count = qerr ? '0 : piece_total;
			predicted_bytes.push_back(r);
			scan_state = SCAN_IDLE;
			held_ch = 8'h00;
			held_valid = 1'b0;
			piece_total = '0;
		end else begin
			held_ch = b;
			held_valid = 1'b1;
		end
	endtask

	task automatic report_mismatch(string msg);
		$display("MISMATCH at %0t: %s", $realtime, msg);
		mismatch_count++;
	endtask

	task automatic check_field(string name, logic [12:0] got, logic [12:0] want);
		if (got !== want) report_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
	endtask

	// Both sides back off in about six percent of cycles, except in one quiet stretch.
	function automatic bit take_break();
		if (cycle_count >= QuietFrom && cycle_count < QuietTo) return 1'b0;
		return $urandom_range(0, 99) < 6;
	endfunction

	task automatic append_text(string s);
		for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
	endtask

	// Moves the line under construction into the send queue, marking its last byte.
	task automatic commit_line();
		line_item_t it;

		for (int i = 0; i < line_buf.size(); i++) begin
			it.ch = line_buf[i];
			it.fin = (i == line_buf.size() - 1);
			send_queue.push_back(it);
		end
		line_buf.delete();
	endtask

	// Builds one random line: mostly well-formed command text with operators, quotes and
	// escapes, some lines with a quote left open, and some pure byte noise.
	task automatic gen_random_line();
		int unsigned kind;
		int unsigned ntok;
		int unsigned n;
		logic [7:0]  q;

		kind = $urandom_range(0, 9);
		if (kind == 0) begin
			n = $urandom_range(1, 8);
			repeat (n) line_buf.push_back(8'($urandom_range(0, 255)));
		end else begin
			ntok = $urandom_range(1, 6);
			repeat (ntok) begin
				case ($urandom_range(0, 7))
					0, 1: begin
						n = $urandom_range(1, 4);
						repeat (n) line_buf.push_back(8'($urandom_range(8'h61, 8'h7A)));
					end
					2: append_text(op_texts[$urandom_range(0, 5)]);
					3: append_text(" ");
					4, 5: begin
						// A closed quote whose body may hide operators.
						q = ($urandom_range(0, 1) != 0) ? CH_SQUOTE : CH_DQUOTE;
						line_buf.push_back(q);
						n = $urandom_range(0, 3);
						repeat (n) begin
							case ($urandom_range(0, 2))
								0: line_buf.push_back(CH_AMP);
								1: line_buf.push_back(CH_PIPE);
								default: line_buf.push_back(8'($urandom_range(8'h61, 8'h7A)));
							endcase
						end
						line_buf.push_back(q);
					end
					6: begin
						line_buf.push_back(CH_BSLASH);
						line_buf.push_back(8'($urandom_range(0, 255)));
					end
					default: line_buf.push_back(8'($urandom_range(0, 255)));
				endcase
			end
			if (kind == 1) begin
				line_buf.push_back(($urandom_range(0, 1) != 0) ? CH_SQUOTE : CH_DQUOTE);
				if ($urandom_range(0, 1) != 0) append_text("ab");
			end
		end
		commit_line();
	endtask

	// Driver: offers the next pending byte whenever the previous one was transferred or the
	// channel stood empty. The byte moved by this edge's transfer is handed to the predictor.
	always @(posedge clk or negedge arst_n) begin : drive_bytes
		line_item_t it;

		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ch.ready) predict_line_byte(in_byte, in_fin);
			if (!in_valid || in_ch.ready) begin
				if (send_queue.size() != 0 && !take_break()) begin
					it = send_queue.pop_front();
					in_valid <= 1'b1;
					in_byte <= it.ch;
					in_fin <= it.fin;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: each result transfer is checked field by field against the oldest prediction.
	always @(posedge clk or negedge arst_n) begin : check_results
		res_t want;

		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_ch.valid && out_ready) begin
				if (predicted_bytes.size() == 0) begin
					report_mismatch($sformatf("result 0x%0h with no prediction waiting",
						out_ch.byte_out));
				end else begin
					want = predicted_bytes.pop_front();
					check_field("byte_out", 13'(out_ch.byte_out), 13'(want.byte_out));
					check_field("piece_start", 13'(out_ch.piece_start),
						13'(want.piece_start));
					check_field("piece_is_operator", 13'(out_ch.piece_is_operator),
						13'(want.piece_is_operator));
					check_field("piece_index", 13'(out_ch.piece_index),
						13'(want.piece_index));
					check_field("last", 13'(out_ch.last), 13'(want.last));
					check_field("quote_error", 13'(out_ch.quote_error),
						13'(want.quote_error));
					check_field("piece_count", out_ch.piece_count, want.piece_count);
				end
			end
			out_ready <= !take_break();
		end
	end

	// Watchdog: ends the run when neither channel has seen a transfer for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			cycle_count <= cycle_count + 1;
			if ((in_valid && in_ch.ready) || (out_ch.valid && out_ready)) begin
				stall_count <= 0;
			end else if (stall_count + 1 >= StallLimit) begin
				$display("timeout after %0d cycles without a transfer", StallLimit);
				$display("shell_line_operator_splitter_top regression: fail");
				$finish;
			end else begin
				stall_count <= stall_count + 1;
			end
		end
	end

	initial begin : stimulus
		int unsigned random_bytes;
		int unsigned before_size;
		bit          long_line_done;

		random_bytes = 0;
		long_line_done = 1'b0;

		// Directed lines: single-byte lines, operators doubled and mixed, an ampersand at the
		// line end, a trailing backslash, escapes and quotes on a piece's first byte, open quotes.
		append_text("x"); commit_line();
		append_text("&"); commit_line();
		append_text("a&"); commit_line();
		append_text("ls\\"); commit_line();
		append_text("a&&b|c;d"); commit_line();
		append_text("||;;&&"); commit_line();
		append_text("a & b"); commit_line();
		append_text("'a|b'c"); commit_line();
		append_text("\"x;y\"z"); commit_line();
		append_text("\\|x"); commit_line();
		append_text("'abc"); commit_line();
		append_text("\"q"); commit_line();
		append_text("|&;;|&b"); commit_line();
		line_buf.push_back(8'h00);
		line_buf.push_back(8'hFF);
		commit_line();

		// Random lines, with one long line of alternating operators, each its own piece.
		while (random_bytes < RandomBytes) begin
			before_size = send_queue.size();
			if (!long_line_done && random_bytes >= RandomBytes / 2) begin
				repeat (100) append_text("|;");
				commit_line();
				long_line_done = 1'b1;
			end
			gen_random_line();
			random_bytes += send_queue.size() - before_size;
		end

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Wait for every byte to be transferred and every predicted result to arrive.
		while (send_queue.size() != 0 || in_valid) @(posedge clk);
		while (predicted_bytes.size() != 0) @(posedge clk);
		// Wait on, so that a stray extra result would still be caught.
		repeat (16) @(posedge clk);

		if (mismatch_count == 0 && predicted_bytes.size() == 0) begin
			$display("shell_line_operator_splitter_top regression: pass");
		end else begin
			$display("shell_line_operator_splitter_top regression: fail");
		end
		$finish;
	end

endmodule

@@ files.f @@
+incdir+design
design/slos_pkg.sv
design/slos_in_if.sv
design/slos_out_if.sv
design/slos_scanner.sv
design/slos_queue.sv
design/shell_line_operator_splitter_top.sv
sim/tb_shell_line_operator_splitter_top.sv
